@@ rtl/wpa_pkg.sv @@
// Package: shared types and constants of the weighted pixel accumulator.
package wpa_pkg;

    localparam int unsigned PIXELS = 16384;
    localparam int unsigned IDX_W  = 14;
    localparam int unsigned CLR_W  = 48;
    localparam int unsigned WS_W   = 32;
    localparam int unsigned DS_W   = 56;
    localparam int unsigned DEP_W  = 24;
    // one entry: r,g,b sums, weight sum, depth sum, depth weight sum, depth seen
    localparam int unsigned ENT_W  = 3 * CLR_W + WS_W + DS_W + WS_W + 1;

    // front queue: depth, pointer and count types sized for it
    localparam int unsigned Q_DEPTH = 2;
    typedef logic [0:0] t_qptr;
    typedef logic [1:0] t_qcnt;

    typedef enum logic [1:0] {
        FUNC_ACC   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]  func;
        logic [13:0] pixel_index;
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
        logic [23:0] depth_in;
        logic        depth_is_number;
        logic [15:0] sample_weight;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [23:0] depth_out;
        logic        depth_valid;
        logic        weight_zero;
    } t_out_item;

    typedef struct packed {
        logic [CLR_W-1:0] red_sum;
        logic [CLR_W-1:0] green_sum;
        logic [CLR_W-1:0] blue_sum;
        logic [WS_W-1:0]  weight_sum;
        logic [DS_W-1:0]  depth_sum;
        logic [WS_W-1:0]  depth_weight_sum;
        logic             depth_seen;
    } t_entry;

    // Command passed from front to back.
    typedef struct packed {
        t_func       func;
        logic [13:0] pixel_index;
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
        logic [23:0] depth_in;
        logic        depth_is_number;
        logic [15:0] sample_weight;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_WRITE,
        ST_DIV,
        ST_OUT
    } t_bstate;

endpackage

@@ rtl/wpa_front.sv @@
// Front end: accepts items, drops ignored ones, queues commands for the back end.
module wpa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  wpa_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output wpa_pkg::t_cmd     o_cmd
);
    wpa_pkg::t_cmd r_q [wpa_pkg::Q_DEPTH];
    wpa_pkg::t_qptr r_wp, r_rp;
    wpa_pkg::t_qcnt r_cnt;
    logic          keep, push, pop;
    wpa_pkg::t_cmd cmd;

    // Classify: pass accumulate, read out and clear, drop the rest
    always_comb begin
        cmd.func            = wpa_pkg::t_func'(i_item.func);
        cmd.pixel_index     = i_item.pixel_index;
        cmd.red_in          = i_item.red_in;
        cmd.green_in        = i_item.green_in;
        cmd.blue_in         = i_item.blue_in;
        cmd.depth_in        = i_item.depth_in;
        cmd.depth_is_number = i_item.depth_is_number;
        cmd.sample_weight   = i_item.sample_weight;
        keep = (i_item.func != wpa_pkg::FUNC_NONE) &&
               ({18'd0, i_item.pixel_index} < 32'(wpa_pkg::PIXELS));
    end

    assign o_ready     = (r_cnt != wpa_pkg::t_qcnt'(wpa_pkg::Q_DEPTH));
    assign push        = i_valid && o_ready && keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // Advance queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // Hold queued commands
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cmd;
    end
endmodule

@@ rtl/wpa_div.sv @@
// Divider: restoring, one quotient bit per cycle.
module wpa_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic [63:0] r_rem, r_quo, r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [64:0] trial;
    logic [63:0] shifted;

    assign shifted = {r_rem[62:0], r_quo[63]};
    assign trial   = {1'b0, shifted} - {1'b0, r_den};
    assign o_done  = r_busy && (r_cnt == 7'd0);
    assign o_quo   = r_quo;

    // Shift in one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
            r_rem  <= '0;
            r_quo  <= i_num;
            r_den  <= i_den;
        end else if (r_busy && r_cnt != 7'd0) begin
            r_cnt <= r_cnt - 7'd1;
            if (!trial[64] && !(r_rem[63])) begin
                r_rem <= trial[63:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else if (r_rem[63]) begin
                r_rem <= shifted - r_den;
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end
endmodule

@@ rtl/wpa_back.sv @@
// Back end: pixel store, read-modify-write and readout with divisions.
module wpa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  wpa_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output wpa_pkg::t_out_item o_item
);
    logic [wpa_pkg::ENT_W-1:0] mem [wpa_pkg::PIXELS];

    wpa_pkg::t_bstate r_st, n_st;
    wpa_pkg::t_cmd    r_cmd;
    wpa_pkg::t_entry  r_ent, r_new;
    logic [wpa_pkg::IDX_W:0] r_sweep;
    logic [31:0] r_pr, r_pg, r_pb;
    logic [39:0] r_pd;
    logic [1:0]  r_dsel;
    logic        r_dstart;
    logic [7:0]  r_ro, r_go, r_bo;
    logic [23:0] r_do;
    logic        r_ovalid;
    wpa_pkg::t_out_item r_out;

    logic        mem_we;
    logic [13:0] mem_wa;
    logic [wpa_pkg::ENT_W-1:0] mem_wd;
    wpa_pkg::t_entry acc;
    logic [63:0] dnum, dden, dquo;
    logic        ddone;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] mx);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = (s > {1'b0, mx}) ? mx : s[63:0];
    endfunction

    wpa_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_dstart),
        .i_num  (dnum),
        .i_den  (dden),
        .o_done (ddone),
        .o_quo  (dquo)
    );

    // Select dividend and divisor for the current division
    always_comb begin
        case (r_dsel)
            2'd0: dnum = {8'd0, r_ent.red_sum, 8'd0} - {16'd0, r_ent.red_sum};
            2'd1: dnum = {8'd0, r_ent.green_sum, 8'd0} - {16'd0, r_ent.green_sum};
            2'd2: dnum = {8'd0, r_ent.blue_sum, 8'd0} - {16'd0, r_ent.blue_sum};
            default: dnum = {8'd0, r_ent.depth_sum};
        endcase
        if (r_dsel == 2'd3) dden = {32'd0, r_ent.depth_weight_sum};
        else                dden = {20'd0, r_ent.weight_sum, 12'd0};
    end

    // Build updated entry from products
    always_comb begin
        acc = r_ent;
        acc.red_sum    = 48'(sat_add({16'd0, r_ent.red_sum}, {32'd0, r_pr},
                                     64'hFFFF_FFFF_FFFF));
        acc.green_sum  = 48'(sat_add({16'd0, r_ent.green_sum}, {32'd0, r_pg},
                                     64'hFFFF_FFFF_FFFF));
        acc.blue_sum   = 48'(sat_add({16'd0, r_ent.blue_sum}, {32'd0, r_pb},
                                     64'hFFFF_FFFF_FFFF));
        acc.weight_sum = 32'(sat_add({32'd0, r_ent.weight_sum}, {48'd0, r_cmd.sample_weight},
                                     64'hFFFF_FFFF));
        if (r_cmd.depth_is_number) begin
            acc.depth_seen = 1'b1;
            if (!r_ent.depth_seen) begin
                acc.depth_sum        = {16'd0, r_pd};
                acc.depth_weight_sum = {16'd0, r_cmd.sample_weight};
            end else begin
                acc.depth_sum = 56'(sat_add({8'd0, r_ent.depth_sum}, {24'd0, r_pd},
                                            64'h00FF_FFFF_FFFF_FFFF));
                acc.depth_weight_sum = 32'(sat_add({32'd0, r_ent.depth_weight_sum},
                                                   {48'd0, r_cmd.sample_weight},
                                                   64'hFFFF_FFFF));
            end
        end
    end

    // Next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            wpa_pkg::ST_SWEEP: begin
                if (r_sweep[13:0] == 14'(wpa_pkg::PIXELS - 1)) n_st = wpa_pkg::ST_IDLE;
            end
            wpa_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.func == wpa_pkg::FUNC_CLEAR) n_st = wpa_pkg::ST_IDLE;
                    else                                   n_st = wpa_pkg::ST_READ;
                end
            end
            wpa_pkg::ST_READ: begin
                if (r_cmd.func == wpa_pkg::FUNC_ACC) n_st = wpa_pkg::ST_MUL;
                else                                 n_st = wpa_pkg::ST_DIV;
            end
            wpa_pkg::ST_MUL:   n_st = wpa_pkg::ST_WRITE;
            wpa_pkg::ST_WRITE: n_st = wpa_pkg::ST_IDLE;
            wpa_pkg::ST_DIV:   if (ddone && r_dsel == 2'd3) n_st = wpa_pkg::ST_OUT;
            wpa_pkg::ST_OUT:   if (!r_ovalid) n_st = wpa_pkg::ST_IDLE;
            default:           n_st = wpa_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb begin
        o_cmd_ready = (r_st == wpa_pkg::ST_IDLE);
        mem_we = 1'b0;
        mem_wa = i_cmd.pixel_index;
        mem_wd = '0;
        case (r_st)
            wpa_pkg::ST_SWEEP: begin
                mem_we = 1'b1;
                mem_wa = r_sweep[13:0];
            end
            wpa_pkg::ST_IDLE: mem_we = i_cmd_valid && (i_cmd.func == wpa_pkg::FUNC_CLEAR);
            wpa_pkg::ST_WRITE: begin
                mem_we = 1'b1;
                mem_wa = r_cmd.pixel_index;
                mem_wd = r_new;
            end
            default: mem_we = 1'b0;
        endcase
    end

    // Store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (r_st == wpa_pkg::ST_READ) r_ent <= wpa_pkg::t_entry'(mem[r_cmd.pixel_index]);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= wpa_pkg::ST_SWEEP;
            r_sweep  <= '0;
            r_dstart <= 1'b0;
            r_dsel   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_dstart <= 1'b0;
            if (r_st == wpa_pkg::ST_SWEEP) r_sweep <= r_sweep + 1'b1;
            if (r_st == wpa_pkg::ST_READ && r_cmd.func == wpa_pkg::FUNC_READ) begin
                r_dstart <= 1'b1;
                r_dsel   <= 2'd0;
            end
            if (r_st == wpa_pkg::ST_DIV && ddone && r_dsel != 2'd3) begin
                r_dsel   <= r_dsel + 2'd1;
                r_dstart <= 1'b1;
            end
            if (r_st == wpa_pkg::ST_DIV && ddone && r_dsel == 2'd3) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_st == wpa_pkg::ST_IDLE && i_cmd_valid) r_cmd <= i_cmd;
        if (r_st == wpa_pkg::ST_MUL) r_new <= acc;
        if (r_st == wpa_pkg::ST_READ || r_st == wpa_pkg::ST_MUL) begin
            r_pr <= 32'(r_cmd.red_in) * 32'(r_cmd.sample_weight);
            r_pg <= 32'(r_cmd.green_in) * 32'(r_cmd.sample_weight);
            r_pb <= 32'(r_cmd.blue_in) * 32'(r_cmd.sample_weight);
            r_pd <= 40'(r_cmd.depth_in) * 40'(r_cmd.sample_weight);
        end
        if (r_st == wpa_pkg::ST_DIV && ddone) begin
            case (r_dsel)
                2'd0: r_ro <= (dquo > 64'd255) ? 8'hFF : dquo[7:0];
                2'd1: r_go <= (dquo > 64'd255) ? 8'hFF : dquo[7:0];
                2'd2: r_bo <= (dquo > 64'd255) ? 8'hFF : dquo[7:0];
                default: r_do <= (dquo > 64'hFF_FFFF) ? 24'hFF_FFFF : dquo[23:0];
            endcase
        end
        if (r_st == wpa_pkg::ST_DIV && ddone && r_dsel == 2'd3) begin
            r_out.red_out     <= (r_ent.weight_sum == '0) ? 8'd0 : r_ro;
            r_out.green_out   <= (r_ent.weight_sum == '0) ? 8'd0 : r_go;
            r_out.blue_out    <= (r_ent.weight_sum == '0) ? 8'd0 : r_bo;
            r_out.depth_out   <= (!r_ent.depth_seen || r_ent.depth_weight_sum == '0) ? 24'd0
                                 : ((dquo > 64'hFF_FFFF) ? 24'hFF_FFFF : dquo[23:0]);
            r_out.depth_valid <= r_ent.depth_seen;
            r_out.weight_zero <= (r_ent.weight_sum == '0);
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;
endmodule

@@ rtl/weighted_pixel_accumulator.sv @@
// Top level: weighted pixel accumulator, front end plus back end.
// An accumulate passes through the back end states store read, multiply and write;
// a clear is written directly from idle; a readout runs four 64-bit divisions
// at one bit per cycle in the shared divider. After reset a clearing
// pass writes all 16384 entries, one per cycle, before the first item is taken
// off the queue; the front queue of two items accepts meanwhile.
module weighted_pixel_accumulator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  wpa_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output wpa_pkg::t_out_item o_item
);
    logic          cmd_valid, cmd_ready;
    wpa_pkg::t_cmd cmd;

    wpa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_cmd_valid(cmd_valid),
        .i_cmd_ready(cmd_ready),
        .o_cmd      (cmd)
    );

    wpa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .o_cmd_ready(cmd_ready),
        .i_cmd      (cmd),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );
endmodule

@@ rtl/wpa_checker.sv @@
// Checker: port-level properties of the weighted pixel accumulator.
module wpa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input wpa_pkg::t_out_item o_item
);
    // Hold a stalled result
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");

    // Colors read zero when the weight sum is zero
    a_zero_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.weight_zero |-> o_item.red_out == 8'd0 &&
        o_item.green_out == 8'd0 && o_item.blue_out == 8'd0)
        else $error("nonzero color with zero weight");

    // Depth reads zero without a valid depth
    a_no_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.depth_valid |-> o_item.depth_out == 24'd0)
        else $error("depth without valid depth");

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");

    // Keep handshake outputs known out of reset
    a_known_hs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_ready, o_valid}))
        else $error("unknown handshake output");
endmodule

bind weighted_pixel_accumulator wpa_checker u_wpa_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_ready(o_ready),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_item (o_item)
);

@@ tb/tb_weighted_pixel_accumulator.sv @@
// Testbench: self-checking stimulus and prediction for the weighted pixel accumulator.
`timescale 1ns / 100ps

module tb_weighted_pixel_accumulator;

    localparam int unsigned MAX_IDLE = 80000;
    localparam int unsigned N_RANDOM = 550;
    localparam int unsigned N_DIR    = 16;
    localparam logic [63:0] SAT48 = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] SAT56 = 64'h00FF_FFFF_FFFF_FFFF;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    wpa_pkg::t_in_item  i_item;
    logic               o_valid;
    logic               i_ready;
    wpa_pkg::t_out_item o_item;

    weighted_pixel_accumulator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // Predicted per-pixel sums; only touched entries are stored, others read as zero
    wpa_pkg::t_entry    pixel_store [int unsigned];
    wpa_pkg::t_out_item pending_reads [$];
    int unsigned error_count;
    int unsigned reads_checked;
    int unsigned idle_cycles;
    int unsigned items_sent;
    bit          idle_off;
    bit          timed_out;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
        if (a > lim) a = lim;
        if (b > lim - a) return lim;
        return a + b;
    endfunction

    function automatic logic [7:0] scale_color(logic [47:0] sum, logic [31:0] wsum);
        logic [63:0] q;
        q = ({16'd0, sum} * 64'd255) / ({32'd0, wsum} << 12);
        return (q > 64'd255) ? 8'd255 : q[7:0];
    endfunction

    function automatic wpa_pkg::t_entry fetch_entry(int unsigned idx);
        if (pixel_store.exists(idx)) return pixel_store[idx];
        return '0;
    endfunction

    // Advance the predicted store by one item; queue the readout expectation
    task automatic predict_item(wpa_pkg::t_in_item it);
        wpa_pkg::t_entry    e;
        wpa_pkg::t_out_item r;
        logic [63:0] dq;
        e = fetch_entry(32'(it.pixel_index));
        case (wpa_pkg::t_func'(it.func))
            wpa_pkg::FUNC_ACC: begin
                e.red_sum    = 48'(add_sat(64'(e.red_sum),
                                           64'(it.red_in) * 64'(it.sample_weight), SAT48));
                e.green_sum  = 48'(add_sat(64'(e.green_sum),
                                           64'(it.green_in) * 64'(it.sample_weight), SAT48));
                e.blue_sum   = 48'(add_sat(64'(e.blue_sum),
                                           64'(it.blue_in) * 64'(it.sample_weight), SAT48));
                e.weight_sum = 32'(add_sat(64'(e.weight_sum), 64'(it.sample_weight), SAT32));
                if (it.depth_is_number) begin
                    if (!e.depth_seen) begin
                        e.depth_sum        = 56'(it.depth_in) * 56'(it.sample_weight);
                        e.depth_weight_sum = 32'(it.sample_weight);
                        e.depth_seen       = 1'b1;
                    end else begin
                        e.depth_sum = 56'(add_sat(64'(e.depth_sum),
                                                  64'(it.depth_in) * 64'(it.sample_weight),
                                                  SAT56));
                        e.depth_weight_sum = 32'(add_sat(64'(e.depth_weight_sum),
                                                         64'(it.sample_weight), SAT32));
                    end
                end
                pixel_store[32'(it.pixel_index)] = e;
            end
            wpa_pkg::FUNC_READ: begin
                r = '0;
                if (e.weight_sum == 0) begin
                    r.weight_zero = 1'b1;
                end else begin
                    r.red_out   = scale_color(e.red_sum, e.weight_sum);
                    r.green_out = scale_color(e.green_sum, e.weight_sum);
                    r.blue_out  = scale_color(e.blue_sum, e.weight_sum);
                end
                if (e.depth_seen && e.depth_weight_sum != 0) begin
                    dq = {8'd0, e.depth_sum} / {32'd0, e.depth_weight_sum};
                    r.depth_out = (dq > 64'hFFFFFF) ? 24'hFFFFFF : dq[23:0];
                end
                r.depth_valid = e.depth_seen;
                pending_reads.push_back(r);
            end
            wpa_pkg::FUNC_CLEAR: pixel_store.delete(32'(it.pixel_index));
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Compare each readout item with the oldest expectation
    always @(posedge i_clk) begin
        wpa_pkg::t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_reads.size() == 0) begin
                report_mismatch("unexpected readout", 32'(o_item.depth_out), 32'd0);
            end else begin
                want = pending_reads.pop_front();
                reads_checked++;
                if (o_item.red_out !== want.red_out)
                    report_mismatch("red_out", 32'(o_item.red_out), 32'(want.red_out));
                if (o_item.green_out !== want.green_out)
                    report_mismatch("green_out", 32'(o_item.green_out), 32'(want.green_out));
                if (o_item.blue_out !== want.blue_out)
                    report_mismatch("blue_out", 32'(o_item.blue_out), 32'(want.blue_out));
                if (o_item.depth_out !== want.depth_out)
                    report_mismatch("depth_out", 32'(o_item.depth_out), 32'(want.depth_out));
                if (o_item.depth_valid !== want.depth_valid)
                    report_mismatch("depth_valid", 32'(o_item.depth_valid),
                                    32'(want.depth_valid));
                if (o_item.weight_zero !== want.weight_zero)
                    report_mismatch("weight_zero", 32'(o_item.weight_zero),
                                    32'(want.weight_zero));
            end
        end
    end

    // Count cycles with no handshake; end the run if the block stalls too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= MAX_IDLE) begin
            timed_out = 1'b1;
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver stalls at random, except during the quiet stretch
    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= idle_off || ($urandom_range(99) >= 27);
    end

    // Drive one item and hold it until accepted; idle afterwards at random
    task automatic send_item(wpa_pkg::t_in_item it);
        i_item  <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_item(it);
        items_sent++;
        @(negedge i_clk);
        if (!idle_off && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
            while (!idle_off && $urandom_range(99) < 27) @(negedge i_clk);
        end
    endtask

    function automatic wpa_pkg::t_in_item make_item(wpa_pkg::t_func f, logic [13:0] idx,
                                                    logic [15:0] r, logic [15:0] g,
                                                    logic [15:0] b, logic [23:0] d,
                                                    logic dn, logic [15:0] w);
        wpa_pkg::t_in_item it;
        it.func = f; it.pixel_index = idx; it.red_in = r; it.green_in = g;
        it.blue_in = b; it.depth_in = d; it.depth_is_number = dn; it.sample_weight = w;
        return it;
    endfunction

    // Directed rows; known results are listed beside them for readouts
    wpa_pkg::t_in_item  dir_items [N_DIR];
    bit                 dir_known [N_DIR];
    wpa_pkg::t_out_item dir_want  [N_DIR];

    initial begin
        wpa_pkg::t_in_item  it;
        wpa_pkg::t_out_item zero_read;
        int unsigned hot_pixel;
        error_count = 0; reads_checked = 0; items_sent = 0; idle_cycles = 0;
        idle_off = 1'b0; timed_out = 1'b0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_item = '0;

        zero_read = '0; zero_read.weight_zero = 1'b1;
        foreach (dir_known[k]) dir_known[k] = 1'b0;
        // fresh pixel reads as zero weight
        dir_items[0]  = make_item(wpa_pkg::FUNC_READ, 14'd0, 0, 0, 0, 0, 0, 0);
        dir_known[0] = 1; dir_want[0] = zero_read;
        // full-scale sample, full weight, max depth
        dir_items[1]  = make_item(wpa_pkg::FUNC_ACC, 14'd0, '1, '1, '1, '1, 1, '1);
        dir_items[2]  = make_item(wpa_pkg::FUNC_READ, 14'd0, 0, 0, 0, 0, 0, 0);
        dir_known[2] = 1;
        dir_want[2] = '{8'd255, 8'd255, 8'd255, 24'hFFFFFF, 1'b1, 1'b0};
        // clear, then read zero
        dir_items[3]  = make_item(wpa_pkg::FUNC_CLEAR, 14'd0, 0, 0, 0, 0, 0, 0);
        dir_items[4]  = make_item(wpa_pkg::FUNC_READ, 14'd0, 0, 0, 0, 0, 0, 0);
        dir_known[4] = 1; dir_want[4] = zero_read;
        // zero weight with valid depth: depth seen, depth weight zero
        dir_items[5]  = make_item(wpa_pkg::FUNC_ACC, 14'h3FFF, 16'h1000, 16'h0800, 0,
                                  24'h010000, 1, 0);
        dir_items[6]  = make_item(wpa_pkg::FUNC_READ, 14'h3FFF, 0, 0, 0, 0, 0, 0);
        dir_known[6] = 1; dir_want[6] = zero_read; dir_want[6].depth_valid = 1'b1;
        // NaN depth only
        dir_items[7]  = make_item(wpa_pkg::FUNC_ACC, 14'd5, 16'h1000, 16'h0800, 0, '1, 0,
                                  16'h8000);
        dir_items[8]  = make_item(wpa_pkg::FUNC_READ, 14'd5, 0, 0, 0, 0, 0, 0);
        dir_known[8] = 1; dir_want[8] = '{8'd255, 8'd127, 8'd0, 24'd0, 1'b0, 1'b0};
        // unused func code is ignored
        dir_items[9]  = make_item(wpa_pkg::FUNC_NONE, 14'd5, '1, '1, '1, '1, 1, '1);
        dir_items[10] = make_item(wpa_pkg::FUNC_ACC, 14'd5, 16'h0400, 16'h2000, 16'hFFFF,
                                  24'h123456, 1, 16'h0001);
        dir_items[11] = make_item(wpa_pkg::FUNC_READ, 14'd5, 0, 0, 0, 0, 0, 0);
        dir_items[12] = make_item(wpa_pkg::FUNC_ACC, 14'd5, 0, 0, 0, 24'h000001, 1, '1);
        dir_items[13] = make_item(wpa_pkg::FUNC_READ, 14'd5, 0, 0, 0, 0, 0, 0);
        dir_items[14] = make_item(wpa_pkg::FUNC_CLEAR, 14'h3FFF, 0, 0, 0, 0, 0, 0);
        dir_items[15] = make_item(wpa_pkg::FUNC_READ, 14'h3FFF, 0, 0, 0, 0, 0, 0);
        dir_known[15] = 1; dir_want[15] = zero_read;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table; typed results override the predictor's
        for (int k = 0; k < N_DIR; k++) begin
            send_item(dir_items[k]);
            if (dir_known[k]) pending_reads[pending_reads.size()-1] = dir_want[k];
        end

        // Random part: mostly bursts of accumulates on a few hot pixels, mixed with reads
        hot_pixel = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            int unsigned sel;
            idle_off = (n >= 200 && n < 280);
            if ($urandom_range(7) == 0) hot_pixel = $urandom_range(16383);
            sel = $urandom_range(99);
            it = make_item(wpa_pkg::FUNC_ACC,
                           14'(($urandom_range(3) == 0) ? $urandom_range(16383) : hot_pixel),
                           16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                           1'($urandom_range(1)), 16'($urandom));
            if ($urandom_range(9) == 0) it.sample_weight = 0;
            if ($urandom_range(9) == 0) it.depth_in = '1;
            if (sel < 60)      it.func = wpa_pkg::FUNC_ACC;
            else if (sel < 88) it.func = wpa_pkg::FUNC_READ;
            else if (sel < 95) it.func = wpa_pkg::FUNC_CLEAR;
            else               it.func = wpa_pkg::FUNC_NONE;
            send_item(it);
        end
        i_valid <= 1'b0;
        idle_off = 1'b0;

        // Drain outstanding readouts, then allow for latency
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);

        $display("Sent %0d items, checked %0d readouts against the predicted store.",
                 items_sent, reads_checked);
        if (error_count == 0 && pending_reads.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
